@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the seam energy block.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sced_pkg.sv @@
// Package for the seam cumulative energy block: widths, codes, constants, flag struct.
// No dependencies.
`timescale 1ns / 1ps
package sced_pkg;

  localparam int MAX_LINE_DEF  = 1024;
  localparam int MAX_LINES_DEF = 4096;

  localparam int ENERGY_W  = 13;
  localparam int MODE_W    = 2;
  localparam int STEP_W    = 2;
  localparam int SUM_W     = 48;
  localparam int COST_W    = 31;
  localparam int LEN_REG_W = 11;
  localparam int CNT_REG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 1'd1;

  localparam logic [LEN_REG_W-1:0] LINE_LENGTH_RST = 11'd1024;
  localparam logic [CNT_REG_W-1:0] LINE_COUNT_RST  = 13'd1024;

  // pixel modes
  localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROTECT = 2'd2;

  // winning upper neighbour
  localparam logic [STEP_W-1:0] STEP_LEFT  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_MID   = 2'd1;
  localparam logic [STEP_W-1:0] STEP_RIGHT = 2'd2;

  localparam logic signed [COST_W-1:0] BIG_COST = 31'sd1000000000;

  typedef struct packed {
    logic first_line;
    logic last_col;
    logic last_line;
    logic fwd_mid;    // middle operand comes from the result being written
    logic fwd_right;  // right operand comes from the result being written
  } pix_flags_t;

endpackage

@@ hw/rtl/sced_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sced_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/sced_front.sv @@
// Input side: column/line counters, register clamping, pixel cost, line store read
// addresses and write-collision detection. Depends on sced_pkg.
`timescale 1ns / 1ps
module sced_front #(
  parameter int MAX_LINE  = sced_pkg::MAX_LINE_DEF,
  parameter int MAX_LINES = sced_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sced_pkg::LEN_REG_W-1:0]      line_length,
  input  logic [sced_pkg::CNT_REG_W-1:0]      line_count,
  input  logic                                accept,
  input  logic [sced_pkg::ENERGY_W-1:0]       energy,
  input  logic [sced_pkg::MODE_W-1:0]         pixel_mode,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_LINE)-1:0]         wr_addr,
  output logic signed [sced_pkg::COST_W-1:0]  cost,
  output logic [$clog2(MAX_LINE)-1:0]         col,
  output logic [$clog2(MAX_LINE)-1:0]         rd_mid_addr,
  output logic [$clog2(MAX_LINE)-1:0]         rd_right_addr,
  output sced_pkg::pix_flags_t                flags
);

  localparam int CW  = $clog2(MAX_LINE);
  localparam int LW  = $clog2(MAX_LINE + 1);
  localparam int LCW = (LW > sced_pkg::LEN_REG_W) ? LW : sced_pkg::LEN_REG_W;
  localparam int IW  = $clog2(MAX_LINES);
  localparam int NW  = $clog2(MAX_LINES + 1);
  localparam int NCW = (NW > sced_pkg::CNT_REG_W) ? NW : sced_pkg::CNT_REG_W;

  logic [CW-1:0] column_count, column_count_next;
  logic [IW-1:0] line_index, line_index_next;
  logic [LCW-1:0] len_ext;
  logic [NCW-1:0] cnt_ext;
  logic [LW-1:0] len;
  logic [NW-1:0] cnt;
  logic last_col, last_line;

  // registers clamped to their usable range
  always_comb begin
    len_ext = LCW'(line_length);
    cnt_ext = NCW'(line_count);
    if (len_ext == '0) begin
      len = LW'(1);
    end else if (len_ext > LCW'(MAX_LINE)) begin
      len = LW'(MAX_LINE);
    end else begin
      len = LW'(len_ext);
    end
    if (cnt_ext == '0) begin
      cnt = NW'(1);
    end else if (cnt_ext > NCW'(MAX_LINES)) begin
      cnt = NW'(MAX_LINES);
    end else begin
      cnt = NW'(cnt_ext);
    end
  end

  assign last_col  = ((LW + 1)'(column_count) + (LW + 1)'(1)) >= (LW + 1)'(len);
  assign last_line = ((NW + 1)'(line_index) + (NW + 1)'(1)) >= (NW + 1)'(cnt);
  assign col       = last_col ? CW'(len - LW'(1)) : column_count;

  assign rd_mid_addr   = col;
  assign rd_right_addr = last_col ? col : CW'(col + CW'(1));

  always_comb begin
    flags.first_line = (line_index == '0);
    flags.last_col   = last_col;
    flags.last_line  = last_line;
    flags.fwd_mid    = wr_en && (wr_addr == rd_mid_addr);
    flags.fwd_right  = wr_en && (wr_addr == rd_right_addr);
  end

  always_comb begin
    case (pixel_mode)
      sced_pkg::MODE_DELETE:  cost = -sced_pkg::BIG_COST;
      sced_pkg::MODE_PROTECT: cost = sced_pkg::BIG_COST;
      default:                cost = $signed(sced_pkg::COST_W'(energy));
    endcase
  end

  always_comb begin
    column_count_next = column_count;
    line_index_next   = line_index;
    if (last_col) begin
      column_count_next = '0;
      line_index_next   = last_line ? '0 : IW'(line_index + IW'(1));
    end else begin
      column_count_next = CW'(col + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_index   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      line_index   <= line_index_next;
    end
  end

endmodule

@@ hw/rtl/sced_step.sv @@
// Compute stage: operand register, neighbour selection, add, seam head tracking and
// the result register with its handshake. Depends on sced_pkg.
`timescale 1ns / 1ps
module sced_step #(
  parameter int MAX_LINE = sced_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  output logic                                in_stall,
  input  logic signed [sced_pkg::COST_W-1:0]  cost,
  input  logic [$clog2(MAX_LINE)-1:0]         col,
  input  sced_pkg::pix_flags_t                flags,
  input  logic signed [sced_pkg::SUM_W-1:0]   rd_mid,
  input  logic signed [sced_pkg::SUM_W-1:0]   rd_right,
  output logic                                wr_en,
  output logic [$clog2(MAX_LINE)-1:0]         wr_addr,
  output logic signed [sced_pkg::SUM_W-1:0]   wr_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [sced_pkg::SUM_W-1:0]   cum_energy,
  output logic [sced_pkg::STEP_W-1:0]         pred_step,
  output logic [$clog2(MAX_LINE)-1:0]         seam_head,
  output logic                                seam_head_valid
);

  localparam int CW = $clog2(MAX_LINE);

  // operand register
  logic                               s1_valid;
  logic signed [sced_pkg::COST_W-1:0] s1_cost;
  logic [CW-1:0]                      s1_col;
  sced_pkg::pix_flags_t               s1_flags;
  logic signed [sced_pkg::SUM_W-1:0]  s1_fwd_sum;

  logic signed [sced_pkg::SUM_W-1:0]  left_upper_hold;
  logic signed [sced_pkg::SUM_W-1:0]  best_sum, best_sum_next;
  logic [CW-1:0]                      best_column, best_column_next;

  logic                               s1_adv;
  logic signed [sced_pkg::SUM_W-1:0]  mid, right, best, sum;
  logic [sced_pkg::STEP_W-1:0]        step;
  logic                               best_upd;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  assign mid   = s1_flags.fwd_mid   ? s1_fwd_sum : rd_mid;
  assign right = s1_flags.fwd_right ? s1_fwd_sum : rd_right;

  always_comb begin
    best = mid;
    step = sced_pkg::STEP_MID;
    if (s1_col != '0 && left_upper_hold < mid) begin
      best = left_upper_hold;
      step = sced_pkg::STEP_LEFT;
    end
    if (!s1_flags.last_col && right <= best) begin
      best = right;
      step = sced_pkg::STEP_RIGHT;
    end
    if (s1_flags.first_line) begin
      sum  = sced_pkg::SUM_W'(s1_cost);
      step = sced_pkg::STEP_MID;
    end else begin
      sum = sced_pkg::SUM_W'(s1_cost) + best;
    end
  end

  // least sum of the final line, first column wins ties
  assign best_upd         = s1_flags.last_line && (s1_col == '0 || sum < best_sum);
  assign best_sum_next    = best_upd ? sum : best_sum;
  assign best_column_next = best_upd ? s1_col : best_column;

  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost    <= cost;
      s1_col     <= col;
      s1_flags   <= flags;
      s1_fwd_sum <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_upper_hold <= '0;
      best_sum        <= '0;
      best_column     <= '0;
    end else if (s1_adv) begin
      left_upper_hold <= s1_flags.last_col ? '0 : mid;
      best_sum        <= best_sum_next;
      best_column     <= best_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cum_energy      <= sum;
      pred_step       <= step;
      seam_head_valid <= s1_flags.last_line && s1_flags.last_col;
      seam_head       <= (s1_flags.last_line && s1_flags.last_col) ? best_column_next : '0;
    end
  end

endmodule

@@ hw/rtl/seam_cumulative_energy_dp_core.sv @@
// Top level of the seam cumulative minimum energy block.
// Depends on sced_pkg, sced_ram, sced_front, sced_step and assert_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): one pixel item per transfer, energy and
//   pixel_mode, in raster order along the seam's line direction.
//   Output channel (out_valid / out_stall): one result item per pixel, cum_energy,
//   pred_step, and on the final pixel of the image seam_head with seam_head_valid.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 line_length, index 1
//   line_count; write only while no item is in flight.
// Timing:
//   An accepted item passes the operand register, then the result register. Throughput
//   is one item per clock unless out_stall holds the result register: the line store
//   has one write and two registered reads per cycle, and the compare/add sits in a
//   single stage between operand and result registers.
//   A write that collides with a read in the same cycle is forwarded.
// Reset:
//   rst (synchronous) clears counters, the running best and the left-neighbour
//   hold, and loads both registers with 1024. The line store is not cleared; the
//   first line ignores what it reads, so no clearing pass is needed.
// Stall:
//   in_stall is high while the operand stage holds an item and the result register
//   is full and stalled; at most two items wait inside and nothing is dropped.
module seam_cumulative_energy_dp_core #(
  parameter int MAX_LINE  = sced_pkg::MAX_LINE_DEF,
  parameter int MAX_LINES = sced_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sced_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sced_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sced_pkg::ENERGY_W-1:0]       energy,
  input  logic [sced_pkg::MODE_W-1:0]         pixel_mode,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sced_pkg::SUM_W-1:0]   cum_energy,
  output logic [sced_pkg::STEP_W-1:0]         pred_step,
  output logic [$clog2(MAX_LINE)-1:0]         seam_head,
  output logic                                seam_head_valid
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_LINE);

  // configuration registers
  logic [sced_pkg::LEN_REG_W-1:0] line_length;
  logic [sced_pkg::CNT_REG_W-1:0] line_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= sced_pkg::LINE_LENGTH_RST;
      line_count  <= sced_pkg::LINE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sced_pkg::REG_LINE_LENGTH: line_length <= cfg_data[sced_pkg::LEN_REG_W-1:0];
        sced_pkg::REG_LINE_COUNT:  line_count  <= cfg_data[sced_pkg::CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic                               accept;
  logic signed [sced_pkg::COST_W-1:0] cost;
  logic [CW-1:0]                      col;
  logic [CW-1:0]                      rd_mid_addr, rd_right_addr;
  sced_pkg::pix_flags_t               flags;
  logic                               wr_en;
  logic [CW-1:0]                      wr_addr;
  logic signed [sced_pkg::SUM_W-1:0]  wr_data;
  logic [sced_pkg::SUM_W-1:0]         rd_mid, rd_right;
  logic                               col_in_range;
  logic                               image_end;
  logic                               head_idle;

  assign accept = in_valid && !in_stall;

  sced_front #(
    .MAX_LINE  (MAX_LINE),
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .line_length   (line_length),
    .line_count    (line_count),
    .accept        (accept),
    .energy        (energy),
    .pixel_mode    (pixel_mode),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .cost          (cost),
    .col           (col),
    .rd_mid_addr   (rd_mid_addr),
    .rd_right_addr (rd_right_addr),
    .flags         (flags)
  );

  // previous line's cumulative sums; read on accept, written when the operand stage advances
  sced_ram #(
    .WIDTH (sced_pkg::SUM_W),
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (accept),
    .raddr_a (rd_mid_addr),
    .raddr_b (rd_right_addr),
    .rdata_a (rd_mid),
    .rdata_b (rd_right)
  );

  sced_step #(
    .MAX_LINE (MAX_LINE)
  ) u_step (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_stall        (in_stall),
    .cost            (cost),
    .col             (col),
    .flags           (flags),
    .rd_mid          ($signed(rd_mid)),
    .rd_right        ($signed(rd_right)),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .cum_energy      (cum_energy),
    .pred_step       (pred_step),
    .seam_head       (seam_head),
    .seam_head_valid (seam_head_valid)
  );

  assign col_in_range = (CW + 1)'(col) < (CW + 1)'(MAX_LINE);
  assign image_end    = accept && flags.last_col && flags.last_line;
  assign head_idle    = out_valid && !seam_head_valid;

  // checks
  `ASSERT_IMPLIES(a_stall_src, clk, rst, in_stall, out_valid && out_stall, "stray input stall")
  `ASSERT_IMPLIES(a_col_range, clk, rst, in_valid, col_in_range, "column beyond line store")
  `ASSERT_IMPLIES(a_head_zero, clk, rst, head_idle, seam_head == '0, "seam head not zero")
  `ASSERT_NEXT(a_image_wrap, clk, rst, image_end, flags.first_line, "no wrap to first line")

endmodule
